FILE: sv/vrp_pkg.sv
// Shared types and constants for the video register port.
package vrp_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT = 2'd1;

   localparam logic [2:0]  STATUS_RESET  = 3'd5;
   localparam logic [15:0] PALETTE_START = 16'h3F00;

   typedef enum logic [2:0] {
      OP_STATUS_READ  = 3'd0,
      OP_SCROLL_WRITE = 3'd1,
      OP_ADDR_WRITE   = 3'd2,
      OP_DATA_READ    = 3'd3,
      OP_STATUS_LOAD  = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] write_value;
      logic [7:0] memory_byte;
      logic       at_vblank_start;
      logic [2:0] status_flags_in;
   } item_type;

   typedef struct packed {
      logic [2:0]  status_bits;
      logic        write_toggle;
      logic [14:0] temp_addr;
      logic [15:0] live_addr;
      logic [7:0]  read_buffer;
      logic [2:0]  fine_x;
   } state_type;

   typedef struct packed {
      logic [7:0] control_value;
      logic [5:0] address_increment;
   } csr_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [15:0] live_address;
      logic [14:0] temp_address;
      logic [2:0]  fine_scroll_x;
      logic        a12_notify;
      logic        a12_level;
      logic        toggle_out;
   } result_type;

endpackage

FILE: sv/vrp_access.sv
// Single-pass access logic: next register state and result for one access.
module vrp_access (
   input  vrp_pkg::item_type   item,
   input  vrp_pkg::state_type  state,
   input  vrp_pkg::csr_type    csr,
   output vrp_pkg::state_type  state_next,
   output vrp_pkg::result_type result
);

   logic [15:0] stepped_addr;
   logic [14:0] temp_second;
   logic [7:0]  read_value;
   logic        notify;

   assign stepped_addr = state.live_addr + {10'd0, csr.address_increment};
   assign temp_second  = {state.temp_addr[14:8], item.write_value};

   always_comb begin
      state_next = state;
      read_value = 8'd0;
      notify     = 1'b0;
      case (item.opcode)
         vrp_pkg::OP_STATUS_READ: begin
            read_value = {state.status_bits, csr.control_value[4:0]};
            if (item.at_vblank_start) begin
               read_value[7] = 1'b0;
            end
            state_next.write_toggle = 1'b1;
            state_next.status_bits  = {1'b0, state.status_bits[1:0]};
         end
         vrp_pkg::OP_SCROLL_WRITE: begin
            if (state.write_toggle) begin
               state_next.temp_addr[4:0] = item.write_value[7:3];
               state_next.fine_x         = item.write_value[2:0];
               state_next.write_toggle   = 1'b0;
            end else begin
               state_next.temp_addr[14:12] = item.write_value[2:0];
               state_next.temp_addr[9:5]   = item.write_value[7:3];
               state_next.write_toggle     = 1'b1;
            end
         end
         vrp_pkg::OP_ADDR_WRITE: begin
            if (state.write_toggle) begin
               // clear bit 14, load six bits into the high byte
               state_next.temp_addr[14:8] = {1'b0, item.write_value[5:0]};
               state_next.write_toggle    = 1'b0;
            end else begin
               state_next.temp_addr    = temp_second;
               state_next.live_addr    = {1'b0, temp_second};
               state_next.write_toggle = 1'b1;
               notify                  = 1'b1;
            end
         end
         vrp_pkg::OP_DATA_READ: begin
            state_next.live_addr = stepped_addr;
            if (stepped_addr < vrp_pkg::PALETTE_START) begin
               read_value              = state.read_buffer;
               state_next.read_buffer  = item.memory_byte;
            end else begin
               read_value = item.memory_byte;
            end
         end
         vrp_pkg::OP_STATUS_LOAD: begin
            state_next.status_bits = item.status_flags_in;
         end
         default: begin
         end
      endcase
   end

   assign result.read_value    = read_value;
   assign result.live_address  = state_next.live_addr;
   assign result.temp_address  = state_next.temp_addr;
   assign result.fine_scroll_x = state_next.fine_x;
   assign result.a12_notify    = notify;
   assign result.a12_level     = notify & state_next.live_addr[12];
   assign result.toggle_out    = state_next.write_toggle;

endmodule

FILE: sv/video_register_port_top.sv
// Top level of the video register port: input stage, state, result stage, CSRs.
//
// Usage:
//   req_*  one bus access per transfer: opcode, write byte, memory byte at the
//          live address, vblank-start flag and the flags for a status load.
//   rsp_*  one result per access: read byte, live and temporary address,
//          fine X scroll, A12 notification and level, write toggle.
//   csr_*  register writes: index 0 control value, index 1 address increment.
//          csr_ready is always high; other indexes are ignored. Write only
//          while no access is in flight.
// Path: an access goes into the input register, then through one pass of
//   access logic into the result register, whose output drives rsp_*.
// Throughput: one access per cycle while not stalled; the input and result
//   registers are a two-deep pipeline; an access is taken while a result waits.
// Stall: while rsp_stall holds a result, the input stage fills and then
//   req_stall rises in the same cycle as the blockage reaches it.
// Reset: synchronous, active high; empties both stages, status flags go to
//   vblank and overflow set, the toggle expects a first write, addresses,
//   fine X and read buffer clear, control 0, increment 1.
module video_register_port_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_write_value,
   input  logic [7:0]  req_memory_byte,
   input  logic        req_at_vblank_start,
   input  logic [2:0]  req_status_flags_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_value,
   output logic [15:0] rsp_live_address,
   output logic [14:0] rsp_temp_address,
   output logic [2:0]  rsp_fine_scroll_x,
   output logic        rsp_a12_notify,
   output logic        rsp_a12_level,
   output logic        rsp_toggle_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [vrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]  csr_data
);

   logic                in_valid_ff;
   vrp_pkg::item_type   in_item_ff;
   vrp_pkg::state_type  state_ff;
   vrp_pkg::state_type  state_in;
   vrp_pkg::csr_type    csr_ff;
   logic                out_valid_ff;
   vrp_pkg::result_type out_result_ff;
   vrp_pkg::result_type result_in;
   logic                advance;
   logic                in_accept;

   // Advance the input stage when the result stage is empty or being drained.
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign in_accept = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   vrp_access u_access (
      .item       (in_item_ff),
      .state      (state_ff),
      .csr        (csr_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // Control state and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.status_bits     <= vrp_pkg::STATUS_RESET;
         state_ff.write_toggle    <= 1'b1;
         state_ff.temp_addr       <= '0;
         state_ff.live_addr       <= '0;
         state_ff.read_buffer     <= '0;
         state_ff.fine_x          <= '0;
         csr_ff.control_value     <= 8'd0;
         csr_ff.address_increment <= 6'd1;
      end else begin
         if (in_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == vrp_pkg::CSR_CONTROL) begin
               csr_ff.control_value <= csr_data;
            end else if (csr_index == vrp_pkg::CSR_INCREMENT) begin
               csr_ff.address_increment <= csr_data[5:0];
            end
         end
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_item_ff.opcode          <= req_opcode;
         in_item_ff.write_value     <= req_write_value;
         in_item_ff.memory_byte     <= req_memory_byte;
         in_item_ff.at_vblank_start <= req_at_vblank_start;
         in_item_ff.status_flags_in <= req_status_flags_in;
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_value    = out_result_ff.read_value;
   assign rsp_live_address  = out_result_ff.live_address;
   assign rsp_temp_address  = out_result_ff.temp_address;
   assign rsp_fine_scroll_x = out_result_ff.fine_scroll_x;
   assign rsp_a12_notify    = out_result_ff.a12_notify;
   assign rsp_a12_level     = out_result_ff.a12_level;
   assign rsp_toggle_out    = out_result_ff.toggle_out;

endmodule

FILE: sv/vrp_checker.sv
// Port-level checker for the video register port, bound to the top level.
module vrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_value,
   input logic [15:0] rsp_live_address,
   input logic        rsp_a12_notify,
   input logic        rsp_a12_level,
   input logic        rsp_toggle_out
);

   // No result straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // A held result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
                                 && $stable(rsp_live_address))
      else $error("stalled result changed");

   // A second address write always leaves the toggle expecting a first write.
   a_notify_toggle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_a12_notify |-> rsp_toggle_out)
      else $error("A12 notify without toggle reset");

   // The A12 level follows bit 12 of the new live address, and is low otherwise.
   a_a12_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_a12_level == (rsp_a12_notify & rsp_live_address[12])))
      else $error("A12 level mismatch");

   // A notified address is a 15-bit copy of the temporary address.
   a_notify_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_a12_notify |-> !rsp_live_address[15])
      else $error("notified live address above 15 bits");

endmodule

bind video_register_port_top vrp_checker u_vrp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_value   (rsp_read_value),
   .rsp_live_address (rsp_live_address),
   .rsp_a12_notify   (rsp_a12_notify),
   .rsp_a12_level    (rsp_a12_level),
   .rsp_toggle_out   (rsp_toggle_out)
);
